/* hw/rtl/gbte_pkg.sv */
`timescale 1ns / 1ps

package gbte_pkg;

  // Field widths of the request and response items
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_MOVE   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

/* hw/rtl/gbte_req_if.sv */
`timescale 1ns / 1ps

interface gbte_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [gbte_pkg::OP_W-1:0]            opcode;
  logic [gbte_pkg::CH_W-1:0]            ch;
  logic signed [gbte_pkg::OFFSET_W-1:0] offset;

  modport source (output valid, output opcode, output ch, output offset, input ready);
  modport sink   (input valid, input opcode, input ch, input offset, output ready);
endinterface

/* hw/rtl/gbte_rsp_if.sv */
`timescale 1ns / 1ps

interface gbte_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [gbte_pkg::STATUS_W-1:0]    status;
  logic [gbte_pkg::COUNT_W-1:0]     cursor_pos;
  logic [gbte_pkg::COUNT_W-1:0]     text_len;

  modport source (output valid, output status, output cursor_pos, output text_len,
                  input ready);
  modport sink   (input valid, input status, input cursor_pos, input text_len,
                  output ready);
endinterface

/* hw/rtl/gap_buffer_text_editor.sv */
`timescale 1ns / 1ps

// Gap buffer text editor.
// req channel: one edit item (opcode, ch, offset). rsp channel: one item per
// request with status, cursor_pos and text_len after the edit.
// The store holds CAPACITY bytes: text before the cursor sits at
// [0, cursor), the gap at [cursor, gap_end), text after it at
// [gap_end, CAPACITY).
// Flow: an item is taken only in IDLE. For insert, delete, rejected moves,
// a zero move and the unused opcode, the item passes EXEC, then DONE loads
// the result register and rsp.valid rises; the next item is taken back in IDLE.
// A move by n positions copies n bytes in COPY: it issues the first read, then
// writes each byte read the cycle before, and leaves once the loop is empty.
// The copy loop and the byte store's one read / one write port set the rate.
// Reset clears the cursor to 0, puts gap_end at CAPACITY and empties the
// result register; the byte store is not cleared, no clearing pass is run.
// If the receiver stalls, the result stays in the output register; a second
// result waits in the final state until that register frees, and req.ready
// stays low meanwhile.
module gap_buffer_text_editor #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst,
  gbte_req_if.sink   req,
  gbte_rsp_if.source rsp
);

  localparam int unsigned AW = $clog2(CAPACITY);      // store address
  localparam int unsigned CW = $clog2(CAPACITY + 1);  // counts 0..CAPACITY
  localparam int unsigned NW = gbte_pkg::OFFSET_W;    // move magnitude
  localparam int unsigned WW = (CW > NW) ? CW : NW;   // compare width

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_COPY = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;

  // captured request
  gbte_pkg::op_t                 op_r;
  logic [gbte_pkg::CH_W-1:0]     ch_r;
  logic [gbte_pkg::OFFSET_W-1:0] off_r;

  // editor state
  logic [CW-1:0] cursor;
  logic [CW-1:0] gap_end;
  gbte_pkg::status_t status_r;

  // copy loop
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [NW-1:0] rd_left;
  logic          rd_pend;
  logic          dir_up;

  // byte store
  logic [7:0]    text_store [CAPACITY];
  logic [7:0]    rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  // output register
  logic                              out_valid;
  logic [gbte_pkg::STATUS_W-1:0]     out_status;
  logic [gbte_pkg::COUNT_W-1:0]      out_cursor;
  logic [gbte_pkg::COUNT_W-1:0]      out_len;

  // ---------------------------------------------------------------------------
  // Execute-stage arithmetic
  // ---------------------------------------------------------------------------
  logic [NW-1:0] mag;
  logic [WW-1:0] mag_w;
  logic [WW-1:0] room_w;
  logic [WW-1:0] cur_w;
  logic [CW-1:0] room;
  logic [CW-1:0] mag_c;
  logic [CW-1:0] cur_m1;
  logic [CW-1:0] gap_m1;
  logic          off_neg;
  logic          off_zero;

  assign off_neg  = off_r[NW-1];
  assign off_zero = (off_r == '0);
  assign mag      = off_neg ? (~off_r + NW'(1)) : off_r;   // -512 gives 512
  assign room     = CW'(CAPACITY) - gap_end;                // bytes after cursor
  assign mag_w    = WW'(mag);
  assign room_w   = WW'(room);
  assign cur_w    = WW'(cursor);
  assign mag_c    = mag_w[CW-1:0];                          // used for the cursor and gap_end steps
  assign cur_m1   = cursor - CW'(1);
  assign gap_m1   = gap_end - CW'(1);

  // separate step adders for the two copy addresses
  logic [AW-1:0] rd_step;
  logic [AW-1:0] wr_step;
  assign rd_step = dir_up ? rd_addr + AW'(1) : rd_addr - AW'(1);
  assign wr_step = dir_up ? wr_addr + AW'(1) : wr_addr - AW'(1);

  // text length for the result
  logic [CW-1:0]      len;
  logic [CW+8:0]      cur_wide;
  logic [CW+8:0]      len_wide;
  assign len      = cursor + room;
  assign cur_wide = {{9{1'b0}}, cursor};
  assign len_wide = {{9{1'b0}}, len};

  logic load_out;
  assign load_out = (state == S_DONE) && (!out_valid || rsp.ready);

  // ---------------------------------------------------------------------------
  // Store write port: insert in EXEC, copy writes in COPY
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr;
    mem_wd = rd_data;
    if (state == S_EXEC && op_r == gbte_pkg::OP_INSERT && cursor != gap_end) begin
      mem_we = 1'b1;
      mem_wa = cursor[AW-1:0];
      mem_wd = ch_r;
    end else if (state == S_COPY && rd_pend) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_store[mem_wa] <= mem_wd;
    end
    rd_data <= text_store[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cursor    <= '0;
      gap_end   <= CW'(CAPACITY);
      rd_left   <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r  <= gbte_pkg::op_t'(req.opcode);
            ch_r  <= req.ch;
            off_r <= req.offset;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status_r <= gbte_pkg::ST_OK;
          state    <= S_DONE;
          unique case (op_r)
            gbte_pkg::OP_INSERT: begin
              if (cursor == gap_end) begin
                status_r <= gbte_pkg::ST_FULL;
              end else begin
                cursor <= cursor + CW'(1);
              end
            end
            gbte_pkg::OP_DELETE: begin
              if (cursor == '0) begin
                status_r <= gbte_pkg::ST_EMPTY;
              end else begin
                cursor <= cur_m1;
              end
            end
            gbte_pkg::OP_MOVE: begin
              if (!off_zero) begin
                if (( off_neg && mag_w > cur_w) ||
                    (!off_neg && mag_w > room_w)) begin
                  status_r <= gbte_pkg::ST_RANGE;
                end else begin
                  // right: copy up from gap_end; left: copy down below cursor
                  dir_up  <= !off_neg;
                  rd_left <= mag;
                  rd_pend <= 1'b0;
                  state   <= S_COPY;
                  if (off_neg) begin
                    rd_addr <= cur_m1[AW-1:0];
                    wr_addr <= gap_m1[AW-1:0];
                    cursor  <= cursor - mag_c;
                    gap_end <= gap_end - mag_c;
                  end else begin
                    rd_addr <= gap_end[AW-1:0];
                    wr_addr <= cursor[AW-1:0];
                    cursor  <= cursor + mag_c;
                    gap_end <= gap_end + mag_c;
                  end
                end
              end
            end
            gbte_pkg::OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
        S_COPY: begin
          // read issued this cycle, written the next
          if (rd_left != '0) begin
            rd_addr <= rd_step;
            rd_left <= rd_left - NW'(1);
          end
          rd_pend <= (rd_left != '0);
          if (rd_pend) begin
            wr_addr <= wr_step;
          end
          if (rd_left == '0 && !rd_pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_status <= status_r;
            out_cursor <= cur_wide[8:0];
            out_len    <= len_wide[8:0];
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.cursor_pos = out_cursor;
  assign rsp.text_len   = out_len;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_gap_order: assert property (@(posedge clk) disable iff (rst)
    (cursor <= gap_end) && (gap_end <= CW'(CAPACITY)))
    else $error("cursor past gap end or gap end past capacity");

  a_copy_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && rd_left == '0 && !rd_pend) |=> (state == S_DONE))
    else $error("copy loop did not finish");

  a_no_write_copy_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && !rd_pend) |-> !mem_we)
    else $error("store written without pending copy byte");

  a_delete_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && op_r == gbte_pkg::OP_DELETE && cursor != '0)
      |=> (cursor == $past(cursor) - CW'(1)))
    else $error("delete did not step cursor back");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !rsp.ready) |=> (state == S_DONE))
    else $error("result dropped while output stalled");

endmodule
